// ===== rtl/core/rds_pkg.sv =====
// ----------------------------------------------------------------------------
// Radial dead-zone package
// Payload types, register indexes and sizes shared by the stick unit's files.
// ----------------------------------------------------------------------------
package rds_pkg;

  localparam int unsigned RegW = 16;
  localparam int unsigned IdxW = 1;

  typedef enum logic [IdxW-1:0] {
    REG_DEAD_ZONE = 1'b0,
    REG_MAX_PUSH  = 1'b1
  } reg_idx_e;

  localparam logic [RegW-1:0] ResetDeadZone = 16'd8000;
  localparam logic [RegW-1:0] ResetMaxPush  = 16'd32767;

  typedef struct packed {
    logic signed [15:0] thumb_x;
    logic signed [15:0] thumb_y;
    logic               which_stick;
  } stick_in_t;

  typedef struct packed {
    logic        [15:0] push_amount;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic               stick_tag;
  } stick_out_t;

endpackage

// ===== rtl/core/rds_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square-root cell
// One restoring step of the integer square root, one result bit per cell.
// ----------------------------------------------------------------------------
module rds_sqrt_cell #(
  parameter int unsigned SqW  = 32,
  parameter int unsigned RootW = 16,
  parameter int unsigned Step = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SqW-1:0]   rem_i,
  input  logic [RootW-1:0] root_i,
  output logic [SqW-1:0]   rem_o,
  output logic [RootW-1:0] root_o
);

  localparam int unsigned Bit = RootW - 1 - Step;

  logic [SqW+1:0]   trial;
  logic [SqW-1:0]   rem_d, rem_q;
  logic [RootW-1:0] root_d, root_q;

  // Trial subtrahend is (2*root + 2^bit) << bit.
  always_comb begin
    trial  = ({2'b0, {(SqW - RootW){1'b0}}, root_i} << (Bit + 1))
           + ((SqW + 2)'(1) << (2 * Bit));
    rem_d  = rem_i;
    root_d = root_i;
    if ({2'b0, rem_i} >= trial) begin
      rem_d       = SqW'({2'b0, rem_i} - trial);
      root_d[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/rds_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step on both axis magnitudes against the root.
// ----------------------------------------------------------------------------
module rds_div_cell #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 16,
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DenW-1:0] den_i,
  input  logic [NumW-1:0] num_x_i,
  input  logic [DenW:0]   rem_x_i,
  input  logic [NumW-1:0] q_x_i,
  input  logic [NumW-1:0] num_y_i,
  input  logic [DenW:0]   rem_y_i,
  input  logic [NumW-1:0] q_y_i,
  output logic [DenW:0]   rem_x_o,
  output logic [NumW-1:0] q_x_o,
  output logic [DenW:0]   rem_y_o,
  output logic [NumW-1:0] q_y_o
);

  localparam int unsigned Bit = NumW - 1 - Step;

  logic [DenW+1:0] sh_x, sh_y;
  logic [DenW:0]   rx_d, ry_d, rx_q, ry_q;
  logic [NumW-1:0] qx_d, qy_d, qx_q, qy_q;

  always_comb begin
    sh_x = {rem_x_i, num_x_i[Bit]};
    sh_y = {rem_y_i, num_y_i[Bit]};
    qx_d = q_x_i;
    qy_d = q_y_i;
    rx_d = sh_x[DenW:0];
    ry_d = sh_y[DenW:0];
    if (sh_x >= {2'b0, den_i}) begin
      rx_d      = (DenW + 1)'(sh_x - {2'b0, den_i});
      qx_d[Bit] = 1'b1;
    end
    if (sh_y >= {2'b0, den_i}) begin
      ry_d      = (DenW + 1)'(sh_y - {2'b0, den_i});
      qy_d[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
  end

  assign rem_x_o = rx_q;
  assign rem_y_o = ry_q;
  assign q_x_o   = qx_q;
  assign q_y_o   = qy_q;

endmodule

// ===== rtl/core/radial_deadzone_stick_unit.sv =====
// ----------------------------------------------------------------------------
// Radial dead-zone stick unit
// Stages: squares, sum, square-root cells, divider cells, final stage.
// Throughput: one beat per cycle while the output is not stalled.
// The chain of square-root and divider cells sets the latency.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module radial_deadzone_stick_unit
  import rds_pkg::*;
#(
  parameter int unsigned AXIS_BITS = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [RegW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stick_in_t         in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stick_out_t        out_data_o
);

  // Widths: the sum of squares needs 2*AXIS_BITS bits, its root AXIS_BITS.
  localparam int unsigned SqW   = 2 * AXIS_BITS;
  localparam int unsigned RootW = AXIS_BITS;
  localparam int unsigned NumW  = AXIS_BITS + FRAC_BITS;
  localparam int unsigned NS    = RootW;
  localparam int unsigned ND    = NumW;
  // Stage 0 forms squares, stage 1 sums, then sqrt cells, divider cells,
  // and a final stage that saturates and applies the dead zone.
  localparam int unsigned Lat   = 2 + NS + ND + 1;

  // Configuration registers.
  logic [RegW-1:0] dz_q, mp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= ResetDeadZone;
      mp_q <= ResetMaxPush;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_DEAD_ZONE: dz_q <= cfg_data_i;
        REG_MAX_PUSH:  mp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole chain advances together when the output register can take a
  // beat; this is a simple stall-all pipeline with the output as its end.
  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Lat-1];

  // Stage 0: take the low AXIS_BITS bits of each axis, square them, split off signs.
  logic signed [AXIS_BITS-1:0] ax, ay;
  assign ax = in_data_i.thumb_x[AXIS_BITS-1:0];
  assign ay = in_data_i.thumb_y[AXIS_BITS-1:0];

  logic [SqW-1:0]       sqx_q, sqy_q;
  logic [AXIS_BITS-1:0] mx0_q, my0_q;
  logic                 nx0_q, ny0_q, tag0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q  <= SqW'(ax * ax);
      sqy_q  <= SqW'(ay * ay);
      mx0_q  <= ax[AXIS_BITS-1] ? AXIS_BITS'(-ax) : AXIS_BITS'(ax);
      my0_q  <= ay[AXIS_BITS-1] ? AXIS_BITS'(-ay) : AXIS_BITS'(ay);
      nx0_q  <= ax[AXIS_BITS-1];
      ny0_q  <= ay[AXIS_BITS-1];
      tag0_q <= in_data_i.which_stick;
    end
  end

  // Stage 1: sum of squares. It fits in SqW bits since it is at most 2^(2A-1).
  logic [SqW-1:0]       sum_q;
  logic [AXIS_BITS-1:0] mx1_q, my1_q;
  logic                 nx1_q, ny1_q, tag1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q  <= sqx_q + sqy_q;
      mx1_q  <= mx0_q;
      my1_q  <= my0_q;
      nx1_q  <= nx0_q;
      ny1_q  <= ny0_q;
      tag1_q <= tag0_q;
    end
  end

  // Side data travels alongside the cells in a shift line.
  typedef struct packed {
    logic [AXIS_BITS-1:0] mx;
    logic [AXIS_BITS-1:0] my;
    logic                 nx;
    logic                 ny;
    logic                 tag;
  } side_t;

  side_t side_q [NS+ND];
  side_t side_in;
  assign side_in = '{mx: mx1_q, my: my1_q, nx: nx1_q, ny: ny1_q, tag: tag1_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int i = 1; i < NS + ND; i++) side_q[i] <= side_q[i-1];
    end
  end

  // Square-root chain.
  logic [SqW-1:0]   srem [NS+1];
  logic [RootW-1:0] sroot [NS+1];
  assign srem[0]  = sum_q;
  assign sroot[0] = '0;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    rds_sqrt_cell #(.SqW(SqW), .RootW(RootW), .Step(g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (srem[g]),
      .root_i (sroot[g]),
      .rem_o  (srem[g+1]),
      .root_o (sroot[g+1])
    );
  end

  // The root travels with the divider chain as the denominator.
  logic [RootW-1:0] den [ND+1];
  logic [NumW-1:0]  numx [ND+1];
  logic [NumW-1:0]  numy [ND+1];
  logic [RootW:0]   rx [ND+1];
  logic [RootW:0]   ry [ND+1];
  logic [NumW-1:0]  qx [ND+1];
  logic [NumW-1:0]  qy [ND+1];

  assign den[0]  = sroot[NS];
  assign numx[0] = {side_q[NS-1].mx, {FRAC_BITS{1'b0}}};
  assign numy[0] = {side_q[NS-1].my, {FRAC_BITS{1'b0}}};
  assign rx[0]   = '0;
  assign ry[0]   = '0;
  assign qx[0]   = '0;
  assign qy[0]   = '0;

  for (genvar g = 0; g < ND; g++) begin : g_div
    logic [RootW-1:0] den_q;
    logic [NumW-1:0]  nx_q, ny_q;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q <= den[g];
        nx_q  <= numx[g];
        ny_q  <= numy[g];
      end
    end
    assign den[g+1]  = den_q;
    assign numx[g+1] = nx_q;
    assign numy[g+1] = ny_q;

    rds_div_cell #(.NumW(NumW), .DenW(RootW), .Step(g)) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .den_i   (den[g]),
      .num_x_i (numx[g]),
      .rem_x_i (rx[g]),
      .q_x_i   (qx[g]),
      .num_y_i (numy[g]),
      .rem_y_i (ry[g]),
      .q_y_i   (qy[g]),
      .rem_x_o (rx[g+1]),
      .q_x_o   (qx[g+1]),
      .rem_y_o (ry[g+1]),
      .q_y_o   (qy[g+1])
    );
  end

  // Final stage: zero direction for zero magnitude, sign, saturation,
  // dead zone and clamp.
  side_t            sd;
  logic [RootW-1:0] m;
  logic [16:0]      mag17, dz17, push17;
  logic [15:0]      push;
  logic [15:0]      dx, dy;

  function automatic logic [15:0] sat_dir(input logic [NumW-1:0] q, input logic neg);
    logic [NumW:0] lim;
    logic [15:0]   r;
    begin
      lim = neg ? (NumW + 1)'(32768) : (NumW + 1)'(32767);
      if ({1'b0, q} > lim) r = neg ? 16'h8000 : 16'h7FFF;
      else r = neg ? 16'(-q) : 16'(q);
      return r;
    end
  endfunction

  always_comb begin
    sd     = side_q[NS+ND-1];
    m      = den[ND];
    mag17  = 17'(m);
    dz17   = {1'b0, dz_q};
    push17 = mag17 - dz17;
    push   = '0;
    if (mag17 > dz17) begin
      push = (push17[15:0] > mp_q) ? mp_q : push17[15:0];
    end
    dx = (m == '0) ? '0 : sat_dir(qx[ND], sd.nx);
    dy = (m == '0) ? '0 : sat_dir(qy[ND], sd.ny);
  end

  stick_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.push_amount <= push;
      out_q.dir_x       <= dx;
      out_q.dir_y       <= dy;
      out_q.stick_tag   <= sd.tag;
    end
  end
  assign out_data_o = out_q;

endmodule

// ===== rtl/core/rds_checker.sv =====
// ----------------------------------------------------------------------------
// Radial dead-zone port checker
// Watches the stick unit's ports for handshake and range slips.
// ----------------------------------------------------------------------------
module rds_checker
  import rds_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       in_ready_o,
  input stick_out_t out_data_o
);

  // A held result beat must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // The unit takes input whenever its output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // The x direction component stays within one in Q1.14.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.dir_x) <= 16384 &&
                     $signed(out_data_o.dir_x) >= -16384))
    else $error("dir_x out of range");

  // Zero push with a zero direction is the only form for a centred stick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dir_x == '0 && out_data_o.dir_y == '0
      |-> out_data_o.push_amount == '0)
    else $error("push without magnitude");

endmodule

bind radial_deadzone_stick_unit rds_checker u_rds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .in_ready_o  (in_ready_o),
  .out_data_o  (out_data_o)
);

// ===== verif/radial_deadzone_stick_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Radial dead-zone stick unit testbench
// Drives stick samples through the valid/ready input, predicts the floored
// magnitude, dead-zone push and Q1.14 direction of each one, and compares
// every result beat field by field, with random idling on both sides and
// register settings changed between phases.
// ----------------------------------------------------------------------------
module radial_deadzone_stick_unit_tb;
  import rds_pkg::*;

  localparam int unsigned Latency    = 49;
  localparam int unsigned CycleLimit = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [IdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  stick_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  stick_out_t out_data_o;

  // Our own copy of the two registers, kept in step with every write.
  logic [RegW-1:0] radius_q = ResetDeadZone;
  logic [RegW-1:0] clamp_q  = ResetMaxPush;

  stick_out_t expected_q[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  // When set, neither side idles at all.
  bit steady = 1'b0;

  always #2 clk_i = ~clk_i;

  radial_deadzone_stick_unit u_top (.*);

  // Floor of the square root, bit by bit from the top.
  function automatic logic [15:0] floor_root(input logic [31:0] sq);
    logic [31:0] res;
    logic [31:0] trial;
    res = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = res | (32'd1 << b);
      if (trial * trial <= sq) res = trial;
    end
    return res[15:0];
  endfunction

  // Direction in Q1.14, truncated towards zero; zero when the magnitude is.
  function automatic logic signed [15:0] unit_dir(input int a, input int m);
    longint q;
    if (m == 0) return '0;
    q = ((a < 0 ? -a : a) * 64'sd16384) / m;
    if (a < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic stick_out_t predict_stick(input stick_in_t s);
    stick_out_t r;
    int x;
    int y;
    int m;
    x = int'(s.thumb_x);
    y = int'(s.thumb_y);
    m = int'(floor_root(32'(x * x + y * y)));
    r.push_amount = '0;
    if (m > radius_q) begin
      r.push_amount = (m - radius_q > clamp_q) ? clamp_q : 16'(m - radius_q);
    end
    r.dir_x = unit_dir(x, m);
    r.dir_y = unit_dir(y, m);
    r.stick_tag = s.which_stick;
    return r;
  endfunction

  // Sends one beat: a random gap first, then valid held until accepted.
  task automatic send_stick(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic tag);
    stick_in_t s;
    s = '{thumb_x: x, thumb_y: y, which_stick: tag};
    while (!steady && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(predict_stick(s));
  endtask

  // Drops valid straight after the last accepted beat, waits for every
  // expected beat, then for the pipeline to drain fully.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_DEAD_ZONE) radius_q = val;
    else clamp_q = val;
    @(posedge clk_i);
  endtask

  // Result side: random stalls, and every accepted beat checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          stick_out_t e;
          e = expected_q.pop_front();
          if (out_data_o.push_amount !== e.push_amount) begin
            $error("push_amount: expected %0d, got %0d", e.push_amount,
                   out_data_o.push_amount);
            fail_count++;
          end
          if (out_data_o.dir_x !== e.dir_x) begin
            $error("dir_x: expected %0d, got %0d", e.dir_x, out_data_o.dir_x);
            fail_count++;
          end
          if (out_data_o.dir_y !== e.dir_y) begin
            $error("dir_y: expected %0d, got %0d", e.dir_y, out_data_o.dir_y);
            fail_count++;
          end
          if (out_data_o.stick_tag !== e.stick_tag) begin
            $error("stick_tag: expected %0d, got %0d", e.stick_tag,
                   out_data_o.stick_tag);
            fail_count++;
          end
        end
      end
      out_ready_i <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Extremes of both axes, the origin, the tag and the dead-zone boundary
  // at the reset radius of 8000.
  task automatic test_directed();
    send_stick(16'sd0, 16'sd0, 1'b0);
    send_stick(-16'sd32768, -16'sd32768, 1'b1);
    send_stick(16'sd32767, 16'sd32767, 1'b0);
    send_stick(-16'sd32768, 16'sd32767, 1'b1);
    send_stick(16'sd32767, 16'sd0, 1'b0);
    send_stick(16'sd0, -16'sd32768, 1'b1);
    send_stick(16'sd8000, 16'sd0, 1'b0);
    send_stick(16'sd8001, 16'sd0, 1'b1);
    send_stick(16'sd0, -16'sd7999, 1'b0);
    send_stick(16'sd1, 16'sd0, 1'b1);
    send_stick(-16'sd1, -16'sd1, 1'b0);
    send_stick(16'sd3, 16'sd4, 1'b1);
    send_stick(16'sd5657, 16'sd5657, 1'b0);
    send_stick(-16'sd5658, 16'sd5657, 1'b1);
    drain_pipe();
  endtask

  // Random samples, half of them small so that the dead zone is crossed often.
  task automatic test_random(input int unsigned count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(1)) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(24000) - 12000);
        y = 16'($urandom_range(24000) - 12000);
      end
      send_stick(x, y, 1'($urandom_range(1)));
    end
    drain_pipe();
  endtask

  // Register settings: zero, the extremes and random values in between.
  task automatic test_settings();
    write_reg(REG_DEAD_ZONE, 16'd0);
    write_reg(REG_MAX_PUSH, 16'd65535);
    test_random(150);
    write_reg(REG_DEAD_ZONE, 16'd65535);
    write_reg(REG_MAX_PUSH, 16'd0);
    test_random(100);
    write_reg(REG_DEAD_ZONE, 16'd46341);
    write_reg(REG_MAX_PUSH, 16'd46341);
    test_random(100);
    write_reg(REG_DEAD_ZONE, 16'($urandom_range(12000)));
    write_reg(REG_MAX_PUSH, 16'($urandom_range(20000)));
    test_random(150);
  endtask

  // A long stretch at full rate, with no idling on either side.
  task automatic test_full_rate();
    steady = 1'b1;
    test_random(200);
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    test_settings();
    test_full_rate();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
